@@ hdl/autoscaled_trace_buffer_assert.svh @@
// Assertion macros for the trace buffer. Each macro is empty in synthesis.
`ifndef AUTOSCALED_TRACE_BUFFER_ASSERT_SVH
`define AUTOSCALED_TRACE_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
`define ATB_ASSERT_SAME(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) else $error(msg);
`define ATB_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) else $error(msg);
`else
`define ATB_ASSERT_SAME(lbl, a, c, msg)
`define ATB_ASSERT_NEXT(lbl, a, c, msg)
`endif
`endif

@@ hdl/atb_pkg.sv @@
package atb_pkg;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_RENDER = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic REG_BOTTOM = 1'b0;
    localparam logic REG_SPAN   = 1'b1;

    localparam logic [5:0] BOTTOM_RESET = 6'd62;
    localparam logic [5:0] SPAN_RESET   = 6'd13;
    localparam logic [7:0] RING_FILL    = 8'd128;

    localparam int PROD_W = 14;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] sample;
    } t_in_word;

    typedef struct packed {
        logic [5:0] row;
        logic [5:0] column;
        logic       last;
    } t_out_word;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [7:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

    // Divide by 8 toward zero, add the midscale offset, clamp to 8 bits.
    function automatic logic [7:0] to_trace(input logic signed [15:0] s);
        logic signed [15:0] b;
        logic signed [12:0] q;
        logic signed [13:0] v;
        b = s[15] ? (s + 16'sd7) : s;
        q = b[15:3];
        v = $signed({q[12], q}) + 14'sd128;
        if (v < 14'sd0) begin
            return 8'd0;
        end else if (v > 14'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

endpackage

@@ hdl/atb_ram.sv @@
module atb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/atb_div.sv @@
module atb_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  atb_pkg::t_div_req i_req,
    output atb_pkg::t_div_rsp o_rsp
);

    localparam int W = atb_pkg::PROD_W;

    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [3:0]   r_cnt, n_cnt;
    logic [7:0]   r_rem, n_rem;
    logic [W-1:0] r_quo, n_quo;
    logic [8:0]   rem_sh;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        rem_sh = {r_rem, r_quo[W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 4'd0;
            n_rem  = 8'd0;
            n_quo  = i_req.dividend;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, i_req.divisor}) begin
                n_rem = 8'(rem_sh - {1'b0, i_req.divisor});
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[7:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ hdl/atb_front.sv @@
module atb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  atb_pkg::t_in_word i_item,
    output logic              o_busy,
    input  logic              i_pop,
    output atb_pkg::t_q_head  o_head
);

    atb_pkg::t_cmd r_q [2];
    logic          r_wr, n_wr;
    logic          r_rd, n_rd;
    logic [1:0]    r_cnt, n_cnt;
    logic          push;
    atb_pkg::t_cmd cmd;

    assign o_busy = (r_cnt == 2'd2);
    // Unused op codes are dropped here and never reach the back.
    assign push = i_start && !o_busy && (i_item.op != atb_pkg::OP_UNUSED);
    assign cmd.kind  = i_item.op;
    assign cmd.value = atb_pkg::to_trace(i_item.sample);

    always_comb begin
        n_wr  = push ? !r_wr : r_wr;
        n_rd  = i_pop ? !r_rd : r_rd;
        n_cnt = r_cnt + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rd];

endmodule

@@ hdl/atb_back.sv @@
module atb_back #(
    parameter int RING_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atb_pkg::t_q_head  i_head,
    output logic              o_pop,
    input  logic [5:0]        i_bottom,
    input  logic [5:0]        i_span,
    output logic              o_strobe,
    output atb_pkg::t_out_word o_result
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
    localparam int PW = atb_pkg::PROD_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_ROW_RD   = 3'd3;
    localparam logic [2:0] ST_ROW_MUL  = 3'd4;
    localparam logic [2:0] ST_DIV_GO   = 3'd5;
    localparam logic [2:0] ST_DIV_WAIT = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [RING_DEPTH-1:0] r_valid, n_valid;
    logic [AW-1:0]         r_wp, n_wp;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_col, n_col;
    logic                  r_pend, n_pend;
    logic                  r_vq;
    logic [7:0]            r_lo, n_lo, r_hi, n_hi, r_range, n_range;
    logic [PW-1:0]         r_prod, n_prod;
    logic                  r_strobe, n_strobe;
    atb_pkg::t_out_word    r_out, n_out;

    logic          we;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata, cur, fold_lo, fold_hi;
    atb_pkg::t_div_req div_req;
    atb_pkg::t_div_rsp div_rsp;

    atb_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (i_head.cmd.value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    atb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Entries never written since reset or clear read as midscale.
    assign cur     = r_vq ? rdata : atb_pkg::RING_FILL;
    assign fold_lo = (cur < r_lo) ? cur : r_lo;
    assign fold_hi = (cur > r_hi) ? cur : r_hi;

    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid;
        n_wp     = r_wp;
        n_idx    = r_idx;
        n_col    = r_col;
        n_pend   = r_pend;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_range  = r_range;
        n_prod   = r_prod;
        n_strobe = 1'b0;
        n_out    = r_out;
        o_pop    = 1'b0;
        we       = 1'b0;
        raddr    = r_idx;
        div_req.start    = 1'b0;
        div_req.dividend = r_prod;
        div_req.divisor  = r_range;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.cmd.kind)
                        atb_pkg::OP_RECORD: begin
                            o_pop = 1'b1;
                            we    = 1'b1;
                            n_valid[r_wp] = 1'b1;
                            n_wp = (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
                        end
                        atb_pkg::OP_CLEAR: begin
                            o_pop   = 1'b1;
                            n_valid = '0;
                            n_wp    = '0;
                        end
                        atb_pkg::OP_RENDER: begin
                            n_state = ST_SCAN;
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_lo    = 8'd255;
                            n_hi    = 8'd0;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                raddr  = r_idx;
                n_pend = 1'b1;
                if (r_pend) begin
                    n_lo = fold_lo;
                    n_hi = fold_hi;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = ST_SCAN_END;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_SCAN_END: begin
                n_lo    = fold_lo;
                n_hi    = fold_hi;
                n_range = (fold_hi == fold_lo) ? 8'd1 : 8'(fold_hi - fold_lo);
                n_idx   = r_wp;
                n_col   = '0;
                n_state = ST_ROW_RD;
            end
            ST_ROW_RD: begin
                raddr   = r_idx;
                n_state = ST_ROW_MUL;
            end
            ST_ROW_MUL: begin
                n_prod  = PW'(8'(cur - r_lo)) * PW'(i_span);
                n_state = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_req.start = 1'b1;
                n_state       = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_strobe     = 1'b1;
                    n_out.row    = (div_rsp.quotient > PW'(i_bottom)) ? 6'd0
                                 : 6'(PW'(i_bottom) - div_rsp.quotient);
                    n_out.column = 6'(r_col);
                    n_out.last   = (r_col == LAST_IDX);
                    if (r_col == LAST_IDX) begin
                        o_pop   = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_idx   = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                        n_state = ST_ROW_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_wp     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_wp     <= n_wp;
            r_strobe <= n_strobe;
        end
        r_idx   <= n_idx;
        r_col   <= n_col;
        r_pend  <= n_pend;
        r_vq    <= r_valid[raddr];
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_range <= n_range;
        r_prod  <= n_prod;
        r_out   <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

@@ hdl/autoscaled_trace_buffer.sv @@
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+-------------------------------
// command   | accepted when start && !busy     | i_item  (op, sample)
// result    | o_strobe, one cycle, no stall    | o_result (row, column, last)
// config    | psel/penable/pwrite, pready high | paddr, pwdata, prdata
//
// A record or clear word retires without a stall once it reaches the
// head of the two-word command queue. A render first scans the ring for
// its minimum and maximum, then reads, scales and divides each column in
// turn with the one-bit-per-cycle divider before strobing its result.
// busy rises only while the command queue is full; results cannot be held
// off by the receiver. Reset is synchronous and active low; it marks every
// ring entry as midscale through per-entry valid bits, so no clearing pass.
`include "autoscaled_trace_buffer_assert.svh"

module autoscaled_trace_buffer #(
    parameter int RING_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  atb_pkg::t_in_word  i_item,
    output logic               o_strobe,
    output atb_pkg::t_out_word o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [5:0]       r_bottom, n_bottom;
    logic [5:0]       r_span, n_span;
    logic             cfg_wr;
    logic             pop;
    atb_pkg::t_q_head head;

    // Registers sit at byte offsets 0 and 4; only bit 2 selects.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        n_bottom = r_bottom;
        n_span   = r_span;
        if (cfg_wr) begin
            if (paddr[2] == atb_pkg::REG_BOTTOM) begin
                n_bottom = pwdata[5:0];
            end else begin
                n_span = pwdata[5:0];
            end
        end
        prdata = (paddr[2] == atb_pkg::REG_SPAN) ? {26'd0, r_span} : {26'd0, r_bottom};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bottom <= atb_pkg::BOTTOM_RESET;
            r_span   <= atb_pkg::SPAN_RESET;
        end else begin
            r_bottom <= n_bottom;
            r_span   <= n_span;
        end
    end

    // The front classifies and queues words; the back executes them.
    atb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_busy  (busy),
        .i_pop   (pop),
        .o_head  (head)
    );

    atb_back #(.RING_DEPTH(RING_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .i_bottom (r_bottom),
        .i_span   (r_span),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Each result passes through the row read, multiply and divide states, so two results never come back to back.
    `ATB_ASSERT_NEXT(a_no_adjacent_strobe, o_strobe, !o_strobe, "back-to-back result strobes")
    `ATB_ASSERT_SAME(a_last_column, o_strobe, o_result.last == (o_result.column == 6'(RING_DEPTH - 1)), "last flag disagrees with column")
    `ATB_ASSERT_NEXT(a_bottom_write, cfg_wr && !paddr[2], r_bottom == $past(pwdata[5:0]), "bottom row write lost")

endmodule
